>>> hw/rtl/vrl_pkg.sv
// Package for the value rate limiter: beat payload structs and fixed constants.
// Used by vrl_divider and value_rate_limiter_with_history; no dependencies.
`timescale 1ns / 1ps
package vrl_pkg;

    typedef struct packed {
        logic [31:0] now_seconds;
        logic [31:0] added_count;
    } in_beat_t;

    typedef struct packed {
        logic        limit_reached;
        logic [47:0] average_rate_q8;
        logic        average_valid;
    } out_beat_t;

    localparam int unsigned ADDR_W = 4;
    localparam logic [ADDR_W-1:0] REG_RATE_LIMIT = 4'h0;
    localparam logic [ADDR_W-1:0] REG_CREDIT_CAP = 4'h4;
    localparam logic [ADDR_W-1:0] REG_START_TIME = 4'h8;

    localparam logic [47:0] AVG_MAX = 48'hFFFF_FFFF_FFFF;

    // Control handshake between the sequencer and the divider.
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> hw/rtl/vrl_divider.sv
// Restoring divider, one quotient bit per cycle: 72-bit dividend by a narrow divisor.
// Depends on vrl_pkg for the control structs.
`timescale 1ns / 1ps
module vrl_divider #(
    parameter int unsigned DW = 72,
    parameter int unsigned SW = 13
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vrl_pkg::div_ctrl_t   ctrl,
    input  logic [DW-1:0]        dividend,
    input  logic [SW-1:0]        divisor,
    output vrl_pkg::div_stat_t   stat,
    output logic [DW-1:0]        quotient
);
    import vrl_pkg::*;

    localparam int unsigned CW = $clog2(DW + 1);

    logic [DW-1:0] quot_reg, quot_next;
    logic [SW:0]   rem_reg, rem_next;
    logic [SW-1:0] dsr_reg, dsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [SW:0]   trial;

    // One shift and subtract step per cycle.
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[SW-1:0], quot_reg[DW-1]};
        if (ctrl.start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next  = trial - {1'b0, dsr_reg};
                quot_next = {quot_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign quotient  = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> hw/rtl/value_rate_limiter_with_history.sv
// Value rate limiter with burst credit and a per-second history ring in one memory.
// A beat walks the ring forward over the seconds elapsed, at most FLUSH_PERIOD - 1 of them,
// then divides for the average, skipped when the history gives no average. A new beat
// is taken only once the result is in the output register; an untaken result holds the next.
// After reset a clearing pass writes zero to every ring entry, during which no input beat is taken.
// Control and configuration registers reset to zero; the sequencer starts in the clearing state.
`timescale 1ns / 1ps
module value_rate_limiter_with_history #(
    parameter int unsigned HISTORY_DEPTH = 512,
    parameter int unsigned FLUSH_PERIOD  = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  vrl_pkg::in_beat_t                in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output vrl_pkg::out_beat_t               out_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [vrl_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import vrl_pkg::*;

    localparam int unsigned IW = $clog2(HISTORY_DEPTH);
    localparam int unsigned SW = IW + 1;
    localparam int unsigned DW = 72;
    localparam logic [IW-1:0] LAST_IDX = IW'(HISTORY_DEPTH - 1);

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_SETTLE = 10'b0000000100,
        ST_ADD    = 10'b0000001000,
        ST_WALK   = 10'b0000010000,
        ST_RDT    = 10'b0000100000,
        ST_WRT    = 10'b0001000000,
        ST_RDAVG  = 10'b0010000000,
        ST_DIV    = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] rate_reg, cap_reg;
    logic [31:0] start_reg;
    logic [63:0] pend_reg, credit_reg, total_reg;
    logic [31:0] last_reg;
    logic [IW-1:0] head_reg, tail_reg, clr_reg;
    logic [31:0] now_reg, add_reg;
    logic [63:0] allow_reg;
    logic [63:0] a_reg;
    logic [SW-1:0] span_reg;
    logic        rd_cnt_reg;
    logic        out_valid_reg;
    out_beat_t   out_reg;

    // History memory, one write and one registered read port.
    logic [63:0] ring_mem [HISTORY_DEPTH];
    logic        mem_we;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [63:0] mem_wdata, mem_rdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= ring_mem[mem_raddr];
    end

    function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] x);
        inc_idx = (x == LAST_IDX) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [IW-1:0] dec_idx(input logic [IW-1:0] x);
        dec_idx = (x == '0) ? LAST_IDX : x - 1'b1;
    endfunction

    // Configuration port.
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr)
            REG_RATE_LIMIT: prdata = rate_reg;
            REG_CREDIT_CAP: prdata = cap_reg;
            REG_START_TIME: prdata = start_reg;
            default:        prdata = '0;
        endcase
    end

    // Divider for the average.
    div_ctrl_t     dctrl;
    div_stat_t     dstat;
    logic [DW-1:0] dquot;

    vrl_divider #(.DW(DW), .SW(SW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (dctrl),
        .dividend ({a_reg, 8'h00}),
        .divisor  (span_reg),
        .stat     (dstat),
        .quotient (dquot)
    );

    // Settlement arithmetic.
    logic [64:0] sum_c, allow_cred, pend_sum;
    logic [63:0] settle_pend, settle_credit;
    always_comb
    begin
        sum_c      = {1'b0, credit_reg} + {1'b0, allow_reg - pend_reg};
        allow_cred = {1'b0, allow_reg} + {1'b0, credit_reg};
        if (allow_reg > pend_reg)
        begin
            settle_credit = (sum_c > {33'd0, cap_reg}) ? {32'd0, cap_reg} : sum_c[63:0];
            settle_pend   = '0;
        end
        else if ({1'b0, pend_reg} <= allow_cred)
        begin
            settle_credit = credit_reg - (pend_reg - allow_reg);
            settle_pend   = '0;
        end
        else
        begin
            settle_credit = '0;
            settle_pend   = pend_reg - allow_reg - credit_reg;
        end
        pend_sum = {1'b0, pend_reg} + {33'd0, add_reg};
    end

    logic [IW-1:0] last_slot;
    logic [SW-1:0] span_w;
    assign last_slot = dec_idx(tail_reg);
    assign span_w = (last_slot >= head_reg) ? SW'(last_slot - head_reg)
                  : SW'({1'b0, last_slot} + SW'(HISTORY_DEPTH) - {1'b0, head_reg});

    logic [IW-1:0] tail_inc;
    assign tail_inc = inc_idx(tail_reg);

    logic [64:0] limit_sum;
    assign limit_sum = {1'b0, allow_reg} + {1'b0, credit_reg};

    // The output register takes a new result once the previous one has left.
    logic out_load;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = tail_reg;
        mem_wdata  = total_reg;
        mem_raddr  = tail_reg;
        dctrl.start = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == LAST_IDX)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_SETTLE;
            end
            ST_SETTLE: state_next = ST_ADD;
            ST_ADD:    state_next = ST_WALK;
            ST_WALK:
            begin
                if (now_reg > last_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = tail_inc;
                    mem_wdata = total_reg;
                end
                else
                begin
                    state_next = ST_RDT;
                end
            end
            ST_RDT:
            begin
                mem_raddr = tail_reg;
                if (rd_cnt_reg)
                    state_next = ST_WRT;
            end
            ST_WRT:
            begin
                mem_we    = 1'b1;
                mem_waddr = tail_reg;
                mem_wdata = mem_rdata + {32'd0, add_reg};
                state_next = ST_RDAVG;
            end
            ST_RDAVG:
            begin
                mem_raddr = rd_cnt_reg ? head_reg : last_slot;
                if (rd_cnt_reg)
                begin
                    if (tail_reg == head_reg || span_w == '0)
                        state_next = ST_OUT;
                    else
                        state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                mem_raddr = head_reg;
                if (!dstat.busy && !dstat.done && rd_cnt_reg)
                    dctrl.start = 1'b1;
                if (dstat.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            rate_reg      <= '0;
            cap_reg       <= '0;
            start_reg     <= '0;
            pend_reg      <= '0;
            credit_reg    <= '0;
            total_reg     <= '0;
            last_reg      <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            rd_cnt_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_wr)
            begin
                unique case (paddr)
                    REG_RATE_LIMIT: rate_reg <= pwdata;
                    REG_CREDIT_CAP:
                    begin
                        cap_reg    <= pwdata;
                        credit_reg <= {32'd0, pwdata};
                    end
                    REG_START_TIME:
                    begin
                        start_reg <= pwdata;
                        last_reg  <= pwdata;
                    end
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + 1'b1;
                ST_SETTLE:
                begin
                    if (now_reg >= last_reg && now_reg - last_reg >= 32'(FLUSH_PERIOD))
                    begin
                        pend_reg   <= settle_pend;
                        credit_reg <= settle_credit;
                        last_reg   <= now_reg;
                    end
                end
                ST_ADD:
                    pend_reg <= pend_sum[64] ? '1 : pend_sum[63:0];
                ST_WALK:
                begin
                    rd_cnt_reg <= 1'b0;
                    if (now_reg > last_reg)
                    begin
                        tail_reg <= tail_inc;
                        if (tail_inc == head_reg)
                            head_reg <= inc_idx(head_reg);
                        last_reg <= last_reg + 1'b1;
                    end
                end
                ST_RDT:
                begin
                    rd_cnt_reg <= ~rd_cnt_reg;
                end
                ST_WRT:
                begin
                    total_reg  <= total_reg + {32'd0, add_reg};
                    rd_cnt_reg <= 1'b0;
                end
                ST_RDAVG:
                begin
                    rd_cnt_reg <= ~rd_cnt_reg;
                end
                ST_DIV:
                begin
                    // First cycle: head slot arrives and is subtracted; next: divider starts.
                    if (!dstat.busy && !dstat.done)
                        rd_cnt_reg <= ~rd_cnt_reg;
                end
                ST_OUT:
                begin
                    rd_cnt_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Payload registers and average operands.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            now_reg   <= in_data.now_seconds;
            add_reg   <= in_data.added_count;
            allow_reg <= 64'(rate_reg) * 64'(FLUSH_PERIOD);
        end
        if (state_reg == ST_RDAVG)
        begin
            span_reg <= span_w;
            if (rd_cnt_reg)
                a_reg <= mem_rdata;
        end
        if (state_reg == ST_DIV && !dstat.busy && !dstat.done && !rd_cnt_reg)
            a_reg <= a_reg - mem_rdata;
        if (out_load)
        begin
            out_reg.limit_reached <= ({1'b0, pend_reg} > limit_sum);
            if (tail_reg == head_reg || span_reg == '0)
            begin
                out_reg.average_rate_q8 <= '0;
                out_reg.average_valid   <= 1'b0;
            end
            else
            begin
                out_reg.average_rate_q8 <= (dquot[DW-1:48] != '0) ? AVG_MAX : dquot[47:0];
                out_reg.average_valid   <= 1'b1;
            end
        end
    end

endmodule
